// ----- hdl/dsp_pkg.sv -----
// Package: shared types, constants and helpers for the dense shortest-path engine.
`timescale 1ns / 1ps

package dsp_pkg;

    localparam int NODES_DEF = 8;
    localparam int NODE_FW   = 3;
    localparam int WEIGHT_W  = 16;
    localparam int DIST_W    = 24;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic [NODE_FW-1:0]  from_node;
        logic [NODE_FW-1:0]  to_node;
        logic [WEIGHT_W-1:0] edge_weight;
        logic                last_entry;
    } entry_t;

    typedef struct packed {
        logic [NODE_FW-1:0] node_index;
        logic [DIST_W-1:0]  path_length;
        logic               reachable;
        logic               last_result;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SEL,
        ST_RELAX,
        ST_OUT
    } state_t;

    // a <= b, with an unreachable node counting as infinite
    function automatic logic dist_le(input logic ra, input logic [DIST_W-1:0] da,
                                     input logic rb, input logic [DIST_W-1:0] db);
        logic le;
        if (!rb)
            le = 1'b1;
        else if (!ra)
            le = 1'b0;
        else
            le = (da <= db);
        return le;
    endfunction

endpackage

// ----- hdl/dsp_ram.sv -----
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module dsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/dense_shortest_path_engine.sv -----
// Top level: single-source shortest paths over a dense adjacency matrix.
`timescale 1ns / 1ps

// Load the adjacency matrix one entry per beat: a beat is taken at a rising edge with start
// high and busy low, and its weight lands in the weight RAM at row from_node, column
// to_node (weight 0 means no edge, out-of-range rows or columns are dropped). Weights persist
// across runs, and every entry a run reads must have been written at some point. The beat
// with last_entry set is stored like any other and then launches a run from node
// source_node (write it through cfg_we/cfg_wdata while busy is low). During a run busy is
// high and no beat is taken. A run starts with a setup state, then NODES-1 passes; each pass
// scans all distances and, when the picked node is reachable, relaxes its row; the scan
// uses one comparator, the relaxation one shared saturating adder and comparator, both
// reading the distance and weight RAMs one word a cycle. NODES results then come out in
// index order, each on result for exactly one cycle with result_valid high; the receiver
// cannot stall them, so it must take every beat. Unreachable nodes report path_length all
// ones and reachable low; distances saturate.

module dense_shortest_path_engine #(
    parameter int NODES = dsp_pkg::NODES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  dsp_pkg::entry_t              entry,
    output logic                         result_valid,
    output dsp_pkg::result_t             result,
    input  logic                         cfg_we,
    input  logic [dsp_pkg::NODE_FW-1:0]  cfg_wdata
);

    import dsp_pkg::*;

    // index widths
    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);
    localparam int PW = (NODES > 2) ? $clog2(NODES - 1) : 1;
    localparam int AW = $clog2(NODES * NODES);
    localparam int XW = IW + NODE_FW;

    // control and datapath registers
    state_t             state_reg,   state_next;
    logic [CW-1:0]      cnt_reg,     cnt_next;
    logic               vld_d_reg,   vld_d_next;
    logic [IW-1:0]      idx_d_reg,   idx_d_next;
    logic [PW-1:0]      pass_reg,    pass_next;
    logic               found_reg,   found_next;
    logic               best_r_reg,  best_r_next;
    logic [DIST_W-1:0]  best_d_reg,  best_d_next;
    logic [IW-1:0]      m_reg,       m_next;
    logic [NODES-1:0]   reach_reg,   reach_next;
    logic [NODES-1:0]   visit_reg,   visit_next;
    logic [NODE_FW-1:0] src_reg;

    // RAM ports
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [WEIGHT_W-1:0] w_rdata;
    logic              d_we;
    logic [IW-1:0]     d_waddr;
    logic [DIST_W-1:0] d_wdata;
    logic [IW-1:0]     d_raddr;
    logic [DIST_W-1:0] d_rdata;

    // helpers
    logic              accept;
    logic [XW-1:0]     from_ext;
    logic [XW-1:0]     to_ext;
    logic [XW-1:0]     src_ext;
    logic [XW-1:0]     idx_ext;
    logic              src_ok;
    logic              scan_end;
    logic [IW-1:0]     cnt_idx;
    logic              cand_upd;
    logic              sel_found;
    logic              sel_r;
    logic [DIST_W-1:0] sel_d;
    logic [IW-1:0]     sel_m;
    logic [DIST_W:0]   sum_wide;
    logic [DIST_W-1:0] sum_sat;
    logic              relax_upd;
    logic              last_pass;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign from_ext = XW'(entry.from_node);
    assign to_ext   = XW'(entry.to_node);
    assign src_ext  = XW'(src_reg);
    assign idx_ext  = XW'(idx_d_reg);
    assign src_ok   = (src_ext < XW'(NODES));
    assign scan_end = (cnt_reg == CW'(NODES));
    assign cnt_idx  = (cnt_reg < CW'(NODES)) ? cnt_reg[IW-1:0] : '0;
    assign last_pass = (pass_reg == PW'(NODES - 2));

    // Matrix load: write the weight RAM on every accepted in-range beat.
    assign w_we    = accept && (from_ext < XW'(NODES)) && (to_ext < XW'(NODES));
    assign w_waddr = AW'(from_ext[IW-1:0]) * AW'(NODES) + AW'(to_ext[IW-1:0]);
    assign w_raddr = AW'(m_reg) * AW'(NODES) + AW'(cnt_idx);
    assign d_raddr = cnt_idx;

    dsp_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (NODES * NODES)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (entry.edge_weight),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    dsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (NODES)
    ) u_dist_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // Selection compare on the word read last cycle; fold it into the running best.
    assign cand_upd  = vld_d_reg && !visit_reg[idx_d_reg] &&
                       (!found_reg || dist_le(reach_reg[idx_d_reg], d_rdata,
                                              best_r_reg, best_d_reg));
    assign sel_found = found_reg || cand_upd;
    assign sel_r     = cand_upd ? reach_reg[idx_d_reg] : best_r_reg;
    assign sel_d     = cand_upd ? d_rdata : best_d_reg;
    assign sel_m     = cand_upd ? idx_d_reg : m_reg;

    // Relaxation: shared saturating adder and compare.
    assign sum_wide  = {1'b0, best_d_reg} + (DIST_W + 1)'(w_rdata);
    assign sum_sat   = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
    assign relax_upd = vld_d_reg && !visit_reg[idx_d_reg] && (w_rdata != '0) &&
                       (!reach_reg[idx_d_reg] || (sum_sat < d_rdata));

    // Results stream straight off the distance RAM read register.
    assign result_valid       = (state_reg == ST_OUT) && vld_d_reg;
    assign result.node_index  = idx_ext[NODE_FW-1:0];
    assign result.path_length = reach_reg[idx_d_reg] ? d_rdata : DIST_MAX;
    assign result.reachable   = reach_reg[idx_d_reg];
    assign result.last_result = (idx_ext == XW'(NODES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            vld_d_reg  <= 1'b0;
            idx_d_reg  <= '0;
            pass_reg   <= '0;
            found_reg  <= 1'b0;
            best_r_reg <= 1'b0;
            best_d_reg <= '0;
            m_reg      <= '0;
            reach_reg  <= '0;
            visit_reg  <= '0;
            src_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            vld_d_reg  <= vld_d_next;
            idx_d_reg  <= idx_d_next;
            pass_reg   <= pass_next;
            found_reg  <= found_next;
            best_r_reg <= best_r_next;
            best_d_reg <= best_d_next;
            m_reg      <= m_next;
            reach_reg  <= reach_next;
            visit_reg  <= visit_next;
            if (cfg_we)
            begin
                src_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        vld_d_next  = 1'b0;
        idx_d_next  = idx_d_reg;
        pass_next   = pass_reg;
        found_next  = found_reg;
        best_r_next = best_r_reg;
        best_d_next = best_d_reg;
        m_next      = m_reg;
        reach_next  = reach_reg;
        visit_next  = visit_reg;
        d_we        = 1'b0;
        d_waddr     = idx_d_reg;
        d_wdata     = sum_sat;

        // Scan states issue one RAM read a cycle and look at the previous one.
        if (state_reg == ST_SEL || state_reg == ST_RELAX || state_reg == ST_OUT)
        begin
            vld_d_next = (cnt_reg < CW'(NODES));
            idx_d_next = cnt_idx;
            cnt_next   = scan_end ? '0 : cnt_reg + CW'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && entry.last_entry)
                begin
                    state_next = ST_INIT;
                end
            end

            ST_INIT:
            begin
                // Clear the marks and seed the source.
                reach_next = '0;
                visit_next = '0;
                if (src_ok)
                begin
                    reach_next[src_ext[IW-1:0]] = 1'b1;
                    d_we    = 1'b1;
                    d_waddr = src_ext[IW-1:0];
                    d_wdata = '0;
                end
                cnt_next   = '0;
                pass_next  = '0;
                found_next = 1'b0;
                state_next = ST_SEL;
            end

            ST_SEL:
            begin
                found_next  = sel_found;
                best_r_next = sel_r;
                best_d_next = sel_d;
                m_next      = sel_m;
                if (scan_end)
                begin
                    found_next = 1'b0;
                    if (!sel_found)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        visit_next[sel_m] = 1'b1;
                        if (sel_r)
                        begin
                            state_next = ST_RELAX;
                        end
                        else if (last_pass)
                        begin
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            pass_next  = pass_reg + PW'(1);
                            state_next = ST_SEL;
                        end
                    end
                end
            end

            ST_RELAX:
            begin
                if (relax_upd)
                begin
                    d_we                  = 1'b1;
                    reach_next[idx_d_reg] = 1'b1;
                end
                if (scan_end)
                begin
                    if (last_pass)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        pass_next  = pass_reg + PW'(1);
                        state_next = ST_SEL;
                    end
                end
            end

            ST_OUT:
            begin
                if (scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Results only appear while a run holds the block busy.
    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result beat outside a run");

    // A last entry always launches a run.
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && entry.last_entry) |=> (state_reg == ST_INIT))
        else $error("last entry did not start a run");

    // The final result closes the stream.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_result) |=> !result_valid)
        else $error("result beat after the final one");

    // Unreachable nodes report the saturated distance.
    a_unreach_max: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.reachable) |-> (result.path_length == DIST_MAX))
        else $error("unreachable node with finite distance");

    // Relaxation never touches a visited node.
    a_relax_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RELAX && d_we) |-> !visit_reg[idx_d_reg])
        else $error("relaxed a visited node");

endmodule

// ----- tb/testbench.sv -----
// Testbench: randomized and directed checks of the dense shortest-path engine.
`timescale 1ns / 1ps

module testbench;
    import dsp_pkg::*;

    localparam int N           = NODES_DEF;
    // Upper bound on the whole simulation, used by the hang check below.
    localparam int CYCLE_LIMIT = 200000;
    // Extra wait after the final drain, before the last check.
    localparam int SETTLE      = 150;
    localparam int RANDOM_BEATS = 44;

    // Predict shortest paths from every accepted matrix beat and check results in order.
    class path_scoreboard;
        logic [WEIGHT_W-1:0] weight_mem [N*N];
        logic [NODE_FW-1:0]  source_node;
        result_t             expected_paths [$];
        int                  errors;

        function new();
            foreach (weight_mem[i])
                weight_mem[i] = '0;
            source_node = '0;
            errors      = 0;
        endfunction

        task report_mismatch(input string msg);
            errors++;
            $display("mismatch at %0t ns: %s", $time, msg);
        endtask

        // Run Dijkstra over the stored matrix and queue one result per node.
        function void solve_paths();
            logic [DIST_W-1:0]   span [N];
            bit                  reach [N];
            bit                  done [N];
            bit                  found;
            bit                  best_r;
            logic [DIST_W-1:0]   best_d;
            int                  pick;
            logic [WEIGHT_W-1:0] w;
            logic [DIST_W:0]     sum;
            result_t             r;

            for (int i = 0; i < N; i++) begin
                span[i]  = '0;
                reach[i] = 1'b0;
                done[i]  = 1'b0;
            end
            if (source_node < N)
                reach[source_node] = 1'b1;

            for (int pass = 0; pass < N - 1; pass++) begin
                found  = 1'b0;
                best_r = 1'b0;
                best_d = '0;
                pick   = 0;
                // Scan upward with <= so ties go to the highest index;
                // an unreachable node counts as infinite.
                for (int i = 0; i < N; i++) begin
                    if (!done[i] && (!found || !best_r || (reach[i] && span[i] <= best_d)))
                    begin
                        found  = 1'b1;
                        best_r = reach[i];
                        best_d = span[i];
                        pick   = i;
                    end
                end
                if (!found)
                    break;
                done[pick] = 1'b1;
                if (reach[pick]) begin
                    for (int x = 0; x < N; x++) begin
                        w = weight_mem[pick*N + x];
                        if (!done[x] && w != '0) begin
                            sum = {1'b0, span[pick]} + (DIST_W + 1)'(w);
                            if (sum > {1'b0, DIST_MAX})
                                sum = {1'b0, DIST_MAX};
                            if (!reach[x] || sum[DIST_W-1:0] < span[x]) begin
                                span[x]  = sum[DIST_W-1:0];
                                reach[x] = 1'b1;
                            end
                        end
                    end
                end
            end

            for (int k = 0; k < N; k++) begin
                r.node_index  = NODE_FW'(k);
                r.path_length = reach[k] ? span[k] : DIST_MAX;
                r.reachable   = reach[k];
                r.last_result = (k == N - 1);
                expected_paths.push_back(r);
            end
        endfunction

        function void note_entry(input entry_t e);
            weight_mem[e.from_node*N + e.to_node] = e.edge_weight;
            if (e.last_entry)
                solve_paths();
        endfunction

        task check_result(input result_t r);
            result_t exp_r;
            if (expected_paths.size() == 0) begin
                report_mismatch($sformatf("unexpected result for node %0d", r.node_index));
                return;
            end
            exp_r = expected_paths.pop_front();
            if (r.node_index !== exp_r.node_index)
                report_mismatch($sformatf("node_index %0d, expected %0d",
                                          r.node_index, exp_r.node_index));
            if (r.path_length !== exp_r.path_length)
                report_mismatch($sformatf("node %0d path_length %0d, expected %0d",
                                          exp_r.node_index, r.path_length,
                                          exp_r.path_length));
            if (r.reachable !== exp_r.reachable)
                report_mismatch($sformatf("node %0d reachable %0b, expected %0b",
                                          exp_r.node_index, r.reachable, exp_r.reachable));
            if (r.last_result !== exp_r.last_result)
                report_mismatch($sformatf("node %0d last_result %0b, expected %0b",
                                          exp_r.node_index, r.last_result,
                                          exp_r.last_result));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    entry_t              entry;
    logic                result_valid;
    result_t             result;
    logic                cfg_we;
    logic [NODE_FW-1:0]  cfg_wdata;

    path_scoreboard sb = new();
    int             cycles = 0;
    int             idle_pct = 0;
    // Sender idle percentages per phase. The third phase stands for receiver
    // stalls, which this block cannot take, so it runs without idling.
    int             idle_table [4] = '{0, 53, 0, 28};

    dense_shortest_path_engine #(
        .NODES(N)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .entry        (entry),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample both handshakes at the edge; the values seen here are the
    // pre-edge ones, so ordering within the time step does not matter.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (result_valid)
                sb.check_result(result);
            if (start && !busy)
                sb.note_entry(entry);
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        logic [WEIGHT_W-1:0] w;
        case ($urandom_range(0, 9))
            0, 1, 2: w = '0;
            3:       w = '1;
            4:       w = WEIGHT_W'(1);
            5, 6:    w = WEIGHT_W'($urandom_range(1, 15));
            default: w = WEIGHT_W'($urandom);
        endcase
        return w;
    endfunction

    // Drop start for a random stretch, scrambling the payload meanwhile.
    task idle_gap();
        int n;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
            start <= 1'b0;
            entry <= entry_t'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold one matrix beat on the port until the block takes it.
    task send_arc(input int from_n, input int to_n, input logic [WEIGHT_W-1:0] w,
                  input bit last);
        entry_t e;
        e.from_node   = NODE_FW'(from_n);
        e.to_node     = NODE_FW'(to_n);
        e.edge_weight = w;
        e.last_entry  = last;
        start <= 1'b1;
        entry <= e;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        idle_gap();
    endtask

    // Wait for every expected result, then for the block to go idle.
    task drain();
        start <= 1'b0;
        while (sb.expected_paths.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task write_source(input logic [NODE_FW-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.source_node = v;
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int beats;
        int grp;
        int burst;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        entry     <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load the whole matrix first so no run ever reads an unwritten
        // weight: a chain 0->1->...->7 of maximum weights, nothing else.
        write_source(NODE_FW'(0));
        for (int r = 0; r < N; r++)
            for (int c = 0; c < N; c++)
                send_arc(r, c, (c == r + 1) ? 16'hFFFF : 16'h0000,
                         (r == N - 1) && (c == N - 1));
        drain();

        // Source at the top index: unit edge, a self-loop, and equal-length
        // routes to node 3; toggle weight bits with alternating patterns.
        write_source(NODE_FW'(7));
        send_arc(7, 0, 16'd1, 0);
        send_arc(7, 7, 16'hFFFF, 0);
        send_arc(0, 3, 16'd1, 0);
        send_arc(7, 3, 16'd2, 0);
        send_arc(2, 5, 16'hAAAA, 0);
        send_arc(5, 2, 16'h5555, 0);
        send_arc(0, 0, 16'd0, 1);
        drain();

        // Tie on node 4, then remove the chain's first edge with a zero
        // weight on the last beat itself.
        write_source(NODE_FW'(0));
        send_arc(0, 4, 16'd3, 0);
        send_arc(3, 4, 16'd2, 0);
        send_arc(0, 1, 16'd0, 1);
        drain();

        // Isolated source: every other node stays unreachable, and the
        // selection falls through ties among infinite distances.
        write_source(NODE_FW'(6));
        send_arc(6, 7, 16'd0, 1);
        drain();

        // A lone last beat that is also the only new edge.
        write_source(NODE_FW'(3));
        send_arc(3, 6, 16'hFFFF, 1);

        // Random bursts of matrix beats, each closed by a last beat.
        beats = 0;
        grp   = 0;
        while (beats < RANDOM_BEATS) begin
            idle_pct = idle_table[(beats * 4) / RANDOM_BEATS];
            if (grp % 4 == 3) begin
                drain();
                case (grp % 12)
                    3:       write_source(NODE_FW'(0));
                    7:       write_source(NODE_FW'(7));
                    default: write_source(NODE_FW'($urandom_range(0, N - 1)));
                endcase
            end
            else if (grp % 5 == 2) begin
                // Hold off the sender until the block has fully caught up.
                drain();
            end
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst; j++) begin
                send_arc($urandom_range(0, N - 1), $urandom_range(0, N - 1),
                         rand_weight(), j == burst - 1);
                beats++;
            end
            grp++;
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (sb.expected_paths.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.expected_paths.size()));
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/dsp_pkg.sv
hdl/dsp_ram.sv
hdl/dense_shortest_path_engine.sv
tb/testbench.sv
